@@ src/dscp_pkg.sv @@
// ----------------------------------------------------------------------------
// dscp_pkg: shared types, constants and functions
// Sizes, modulus, controller state and command/status structs for the
// distinct-subsequence counter with value-ordered prefix sum.
// ----------------------------------------------------------------------------
package dscp_pkg;

   localparam int MAX_VALUE   = 1024;
   localparam int VAL_W       = 11;
   localparam int RES_W       = 30;
   localparam int ADDR_W      = $clog2(MAX_VALUE);
   // tree update walk may step past MAX_VALUE, up to twice it
   localparam int IDX_W       = $clog2(MAX_VALUE + 1) + 1;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 64;

   localparam logic [RES_W-1:0] MODP = 30'd998244353;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_SUB,
      ST_CNT_INC,
      ST_CNT_WR,
      ST_PFX,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic cnt_sub;
      logic cnt_inc;
      logic cnt_wr;
      logic pfx_run;
      logic add_init;
      logic add_run;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic pfx_done;
      logic add_done;
      logic rsp_free;
   } sts_type;

   function automatic logic [RES_W-1:0] add_mod(input logic [RES_W-1:0] a,
                                                input logic [RES_W-1:0] b);
      logic [RES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODP}) begin
         s = s - {1'b0, MODP};
      end
      return s[RES_W-1:0];
   endfunction

   function automatic logic [RES_W-1:0] sub_mod(input logic [RES_W-1:0] a,
                                                input logic [RES_W-1:0] b);
      logic [RES_W:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + {1'b0, MODP} - {1'b0, b};
      end
      return s[RES_W-1:0];
   endfunction

   // zero maps to one, anything above the range to MAX_VALUE
   function automatic logic [IDX_W-1:0] clamp_value(input logic [VAL_W-1:0] raw);
      logic [IDX_W-1:0] v;
      if (raw == '0) begin
         v = IDX_W'(1);
      end else if (int'(raw) > MAX_VALUE) begin
         v = IDX_W'(MAX_VALUE);
      end else begin
         v = IDX_W'(raw);
      end
      return v;
   endfunction

endpackage

@@ src/dscp_ram.sv @@
// ----------------------------------------------------------------------------
// dscp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dscp_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ src/dscp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dscp_ctrl: sequencing controller
// Steps each beat through count update, prefix walk and tree update, and
// runs the clearing sweep after reset and on a clear beat.
// ----------------------------------------------------------------------------
module dscp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_action,
   output logic              req_tready,
   input  dscp_pkg::sts_type sts,
   output dscp_pkg::cmd_type cmd
);
   import dscp_pkg::*;

   state_type state_ff, state_in;
   logic      clr_rsp_ff, clr_rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               // a clear beat owes one all-zero result, reset does not
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               if (req_action) begin
                  state_in   = ST_CLEAR;
                  clr_rsp_in = 1'b1;
               end else begin
                  state_in = ST_CNT_RD;
               end
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_SUB;
         end
         ST_CNT_SUB: begin
            cmd.cnt_sub = 1'b1;
            state_in    = ST_CNT_INC;
         end
         ST_CNT_INC: begin
            cmd.cnt_inc = 1'b1;
            state_in    = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = ST_PFX;
         end
         ST_PFX: begin
            if (sts.pfx_done) begin
               cmd.add_init = 1'b1;
               state_in     = ST_ADD;
            end else begin
               cmd.pfx_run = 1'b1;
            end
         end
         ST_ADD: begin
            if (sts.add_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.add_run = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

@@ src/dscp_dpath.sv @@
// ----------------------------------------------------------------------------
// dscp_dpath: datapath
// Count table, Fenwick sum tree, running total, walk index and the
// output register.
// ----------------------------------------------------------------------------
module dscp_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  dscp_pkg::cmd_type           cmd,
   output dscp_pkg::sts_type           sts,
   input  logic [dscp_pkg::VAL_W-1:0]  req_value,
   input  logic                        rsp_tready,
   output logic                        rsp_valid,
   output logic [dscp_pkg::RES_W-1:0]  rsp_count,
   output logic [dscp_pkg::RES_W-1:0]  rsp_smaller
);
   import dscp_pkg::*;

   logic [IDX_W-1:0]  v_ff, v_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [RES_W-1:0]  total_ff, total_in;
   logic [RES_W-1:0]  cnt_ff, cnt_in;
   logic [RES_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [RES_W-1:0]  rsp_smaller_ff, rsp_smaller_in;

   logic [ADDR_W-1:0] vaddr;
   logic [ADDR_W-1:0] taddr;
   logic [IDX_W-1:0]  lowbit;
   logic [RES_W-1:0]  cnt_rd;
   logic [RES_W-1:0]  tree_rd;
   logic [RES_W-1:0]  tree_sum;
   logic              cnt_we;
   logic [ADDR_W-1:0] cnt_wa;
   logic [RES_W-1:0]  cnt_wd;
   logic              tree_we;
   logic [ADDR_W-1:0] tree_wa;
   logic [RES_W-1:0]  tree_wd;

   // table entry for value v lives at address v-1
   assign vaddr    = ADDR_W'(v_ff - IDX_W'(1));
   assign taddr    = ADDR_W'(idx_ff - IDX_W'(1));
   assign lowbit   = idx_ff & (~idx_ff + IDX_W'(1));
   assign tree_sum = add_mod(tree_rd, cnt_ff);

   assign cnt_we  = cmd.sweep | cmd.cnt_wr;
   assign cnt_wa  = cmd.sweep ? sweep_ff : vaddr;
   assign cnt_wd  = cmd.sweep ? '0 : cnt_ff;
   assign tree_we = cmd.sweep | (cmd.add_run & pend_ff);
   assign tree_wa = cmd.sweep ? sweep_ff : waddr_ff;
   assign tree_wd = cmd.sweep ? '0 : tree_sum;

   dscp_ram #(.WIDTH(RES_W), .DEPTH(MAX_VALUE)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_addr (vaddr),
      .rd_data (cnt_rd)
   );

   dscp_ram #(.WIDTH(RES_W), .DEPTH(MAX_VALUE)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_wa),
      .wr_data (tree_wd),
      .rd_addr (taddr),
      .rd_data (tree_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff           <= v_in;
      idx_ff         <= idx_in;
      waddr_ff       <= waddr_in;
      total_ff       <= total_in;
      cnt_ff         <= cnt_in;
      acc_ff         <= acc_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_smaller_ff <= rsp_smaller_in;
   end

   always_comb begin
      v_in           = v_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      waddr_in       = waddr_ff;
      sweep_in       = sweep_ff;
      total_in       = total_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_smaller_in = rsp_smaller_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;

      if (cmd.sweep) begin
         sweep_in = (sweep_ff == ADDR_W'(MAX_VALUE - 1)) ? '0 : sweep_ff + ADDR_W'(1);
         total_in = '0;
         cnt_in   = '0;
         acc_in   = '0;
      end

      if (cmd.accept) begin
         v_in = clamp_value(req_value);
      end

      if (cmd.cnt_sub) begin
         cnt_in = sub_mod(total_ff, cnt_rd);
      end

      if (cmd.cnt_inc) begin
         cnt_in = add_mod(cnt_ff, RES_W'(1));
      end

      if (cmd.cnt_wr) begin
         total_in = add_mod(total_ff, cnt_ff);
         idx_in   = v_ff - IDX_W'(1);
         pend_in  = 1'b0;
         acc_in   = '0;
      end

      // prefix walk: one tree read issued per cycle, data folded in next cycle
      if (cmd.pfx_run) begin
         if (pend_ff) begin
            acc_in = add_mod(acc_ff, tree_rd);
         end
         if (idx_ff != '0) begin
            idx_in  = idx_ff & (idx_ff - IDX_W'(1));
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.add_init) begin
         idx_in  = v_ff;
         pend_in = 1'b0;
      end

      // update walk: read at idx, write back in the next cycle; addresses rise
      if (cmd.add_run) begin
         if (int'(idx_ff) <= MAX_VALUE) begin
            waddr_in = taddr;
            idx_in   = idx_ff + lowbit;
            pend_in  = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_count_in   = cnt_ff;
         rsp_smaller_in = acc_ff;
      end
   end

   assign sts.sweep_last = (sweep_ff == ADDR_W'(MAX_VALUE - 1));
   assign sts.pfx_done   = (idx_ff == '0) & ~pend_ff;
   assign sts.add_done   = (int'(idx_ff) > MAX_VALUE) & ~pend_ff;
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_smaller = rsp_smaller_ff;

endmodule

@@ src/distinct_subseq_count_prefix_sum_core.sv @@
// ----------------------------------------------------------------------------
// distinct_subseq_count_prefix_sum_core: distinct-subsequence counter
// Per value: distinct subsequences from here and the sum of counts already
// seen for smaller values, both modulo 998244353.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per sequence value, fed from the last position to
//   the first. req_tuser is the action (1 clears every store), req_tdata the
//   value. rsp_ channel: one beat per request beat, in order.
//   A value beat runs from accept to rsp_tvalid through the count
//   read-modify-write (read, subtract, increment, write), then the prefix
//   and update walks, one sum-tree RAM access per cycle, each draining its
//   last read, then the load of the output register. One beat is in
//   flight at a time, so a new value beat is taken only after the last
//   one has loaded its result.
//   A clear beat sweeps both 1024-entry tables, one address per cycle, then
//   returns a beat with both fields zero.
//   After reset the same clearing sweep runs with req_tready low.
//   The result sits in an output register; the next beat is accepted while it
//   waits. If rsp_tready stays low, the following result holds in the core
//   until the register frees.
// ----------------------------------------------------------------------------
module distinct_subseq_count_prefix_sum_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dscp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [10:0] value
   input  logic                                req_tuser,  // [0] action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dscp_pkg::RSP_TDATA_W-1:0]    rsp_tdata   // [29:0] count_from_here,
                                                            // [59:30] smaller_sum
);
   import dscp_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic [RES_W-1:0] rsp_count;
   logic [RES_W-1:0] rsp_smaller;

   dscp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dscp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_value   (req_tdata[VAL_W-1:0]),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_count   (rsp_count),
      .rsp_smaller (rsp_smaller)
   );

   assign rsp_tdata = {(RSP_TDATA_W - 2 * RES_W)'(0), rsp_smaller, rsp_count};

endmodule
